>>> design/snst_pkg.sv
`default_nettype none
package snst_pkg;

  localparam int NAME_W      = 64;
  localparam int SCORE_W     = 32;
  localparam int KIND_W      = 2;
  localparam int IDX_IN_W    = 6;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 7;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [2:0]          res_t;

  localparam kind_t KIND_ADD    = 2'd0;
  localparam kind_t KIND_UPDATE = 2'd1;
  localparam kind_t KIND_READ   = 2'd2;
  localparam kind_t KIND_NONE   = 2'd3;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_MISSING = 2'd2;
  localparam status_t ST_RANGE   = 2'd3;

  // Which result the datapath presents when the item finishes.
  localparam res_t RES_ZERO    = 3'd0;
  localparam res_t RES_ITEM    = 3'd1;
  localparam res_t RES_MEM     = 3'd2;
  localparam res_t RES_FULL    = 3'd3;
  localparam res_t RES_MISSING = 3'd4;
  localparam res_t RES_RANGE   = 3'd5;

  typedef struct packed {
    logic [NAME_W-1:0]         name;
    logic signed [SCORE_W-1:0] score;
  } ent_t;

  typedef struct packed {
    logic latch;
    logic add_start;
    logic shift_step;
    logic add_place;
    logic srch_start;
    logic srch_read;
    logic srch_hit;
    logic srch_up;
    logic srch_down;
    logic read_issue;
    logic set_res;
    res_t res;
    logic emit;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  pos_zero;
    logic  held_gt;
    logic  name_gt;
    logic  held_eq;
    logic  live;
    logic  idx_bad;
    logic  out_busy;
  } sts_t;

endpackage
`default_nettype wire

>>> design/snst_if.sv
`default_nettype none
interface snst_in_if;
  logic                                valid;
  logic                                ready;
  logic [snst_pkg::KIND_W-1:0]         kind;
  logic [snst_pkg::NAME_W-1:0]         entry_name;
  logic signed [snst_pkg::SCORE_W-1:0] entry_score;
  logic [snst_pkg::IDX_IN_W-1:0]       entry_index;

  modport source (output valid, kind, entry_name, entry_score, entry_index, input ready);
  modport sink (input valid, kind, entry_name, entry_score, entry_index, output ready);
endinterface

interface snst_out_if;
  logic                                valid;
  logic                                ready;
  logic [snst_pkg::STATUS_W-1:0]       status;
  logic [snst_pkg::NAME_W-1:0]         out_name;
  logic signed [snst_pkg::SCORE_W-1:0] out_score;
  logic [snst_pkg::COUNT_OUT_W-1:0]    out_count;

  modport source (output valid, status, out_name, out_score, out_count, input ready);
  modport sink (input valid, status, out_name, out_score, out_count, output ready);
endinterface
`default_nettype wire

>>> design/sorted_name_score_table_core.sv
`default_nettype none
// Sorted name and score table. Holds up to CAPACITY entries in ascending name order
// in a single-port-write, single-port-read memory, and answers every item with
// exactly one result beat. An add walks down from the top of the table, moving one
// entry up per cycle until it finds its place. An update binary searches the held
// entries. A read at an index, a full table and an unused kind are answered from
// the decode state. One item is worked on at a time; the result sits in an output
// register, so the next item is taken while it waits to be drained. The stores are
// not cleared at reset, so there is no start-up pass: only positions below the held
// count are ever read.
module sorted_name_score_table_core #(
  parameter int CAPACITY   = 64,
  parameter int NAME_CHARS = 8
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  snst_in_if.sink     in_ch,
  snst_out_if.source  out_ch
);

  snst_pkg::cmd_t cmd;
  snst_pkg::sts_t sts;

  snst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  snst_dp #(
    .CAPACITY   (CAPACITY),
    .NAME_CHARS (NAME_CHARS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_ch.kind),
    .in_entry_name  (in_ch.entry_name),
    .in_entry_score (in_ch.entry_score),
    .in_entry_index (in_ch.entry_index),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_status     (out_ch.status),
    .out_name       (out_ch.out_name),
    .out_score      (out_ch.out_score),
    .out_count      (out_ch.out_count)
  );

endmodule
`default_nettype wire

>>> design/snst_ctrl.sv
`default_nettype none
module snst_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire snst_pkg::sts_t  sts,
  output snst_pkg::cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_ADD    = 3'd2;
  localparam logic [2:0] S_TEST   = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.kind)
          snst_pkg::KIND_ADD: begin
            if (sts.full) begin
              cmd.set_res = 1'b1;
              cmd.res     = snst_pkg::RES_FULL;
              state_nxt   = S_FINISH;
            end else begin
              cmd.add_start = 1'b1;
              state_nxt     = S_ADD;
            end
          end
          snst_pkg::KIND_UPDATE: begin
            cmd.srch_start = 1'b1;
            state_nxt      = S_TEST;
          end
          snst_pkg::KIND_READ: begin
            cmd.set_res = 1'b1;
            if (sts.idx_bad) begin
              cmd.res = snst_pkg::RES_RANGE;
            end else begin
              cmd.read_issue = 1'b1;
              cmd.res        = snst_pkg::RES_MEM;
            end
            state_nxt = S_FINISH;
          end
          snst_pkg::KIND_NONE: begin
            cmd.set_res = 1'b1;
            cmd.res     = snst_pkg::RES_ZERO;
            state_nxt   = S_FINISH;
          end
        endcase
      end
      S_ADD: begin
        // The entry below the insertion point is in the read register this cycle.
        if (!sts.pos_zero && sts.held_gt) begin
          cmd.shift_step = 1'b1;
        end else begin
          cmd.add_place = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.res       = snst_pkg::RES_ITEM;
          state_nxt     = S_FINISH;
        end
      end
      S_TEST: begin
        if (sts.live) begin
          cmd.srch_read = 1'b1;
          state_nxt     = S_CMP;
        end else begin
          cmd.set_res = 1'b1;
          cmd.res     = snst_pkg::RES_MISSING;
          state_nxt   = S_FINISH;
        end
      end
      S_CMP: begin
        if (sts.held_eq) begin
          cmd.srch_hit = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res      = snst_pkg::RES_ITEM;
          state_nxt    = S_FINISH;
        end else if (sts.name_gt) begin
          cmd.srch_up = 1'b1;
          state_nxt   = S_TEST;
        end else begin
          cmd.srch_down = 1'b1;
          state_nxt     = S_TEST;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/snst_dp.sv
`default_nettype none
module snst_dp #(
  parameter int CAPACITY   = 64,
  parameter int NAME_CHARS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire snst_pkg::cmd_t                      cmd,
  output snst_pkg::sts_t                           sts,
  input  wire logic [snst_pkg::KIND_W-1:0]         in_kind,
  input  wire logic [snst_pkg::NAME_W-1:0]         in_entry_name,
  input  wire logic signed [snst_pkg::SCORE_W-1:0] in_entry_score,
  input  wire logic [snst_pkg::IDX_IN_W-1:0]       in_entry_index,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic [snst_pkg::STATUS_W-1:0]            out_status,
  output logic [snst_pkg::NAME_W-1:0]              out_name,
  output logic signed [snst_pkg::SCORE_W-1:0]      out_score,
  output logic [snst_pkg::COUNT_OUT_W-1:0]         out_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IW    = snst_pkg::IDX_IN_W;
  localparam int CW    = snst_pkg::COUNT_OUT_W;

  snst_pkg::ent_t mem [CAPACITY];

  snst_pkg::kind_t                     kind_r;
  logic [snst_pkg::NAME_W-1:0]         name_r;
  logic signed [snst_pkg::SCORE_W-1:0] score_r;
  logic [IW-1:0]                       index_r;
  logic [CNT_W-1:0]                    count_r;
  logic [CNT_W-1:0]                    pos_r;
  logic [CNT_W-1:0]                    low_r;
  logic [CNT_W-1:0]                    hp1_r;
  snst_pkg::res_t                      res_r;
  snst_pkg::ent_t                      rdata_r;
  logic                                out_valid_r;
  snst_pkg::status_t                   out_status_r;
  logic [snst_pkg::NAME_W-1:0]         out_name_r;
  logic signed [snst_pkg::SCORE_W-1:0] out_score_r;
  logic [CW-1:0]                       out_count_r;

  logic [snst_pkg::NAME_W-1:0] shaped;
  logic                        alive;
  logic [CNT_W:0]              mid_sum;
  logic [CNT_W-1:0]            mid;
  logic [CNT_W-1:0]            cnt_m1;
  logic [CNT_W-1:0]            pos_m1;
  logic [CNT_W-1:0]            pos_m2;
  logic [CNT_W+IW-1:0]         idx_ext;
  logic [CNT_W+IW-1:0]         cnt_ext;
  logic [CNT_W+CW-1:0]         cnt_out_ext;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  snst_pkg::ent_t              wr_data;
  logic                        rd_en;
  logic [IDX_W-1:0]            rd_addr;

  // A name keeps its first NAME_CHARS characters and stops at its first zero byte.
  always_comb begin
    alive = 1'b1;
    for (int b = 7; b >= 0; b--) begin
      if ((7 - b) >= NAME_CHARS || in_entry_name[8*b +: 8] == 8'h00) begin
        alive = 1'b0;
      end
      shaped[8*b +: 8] = alive ? in_entry_name[8*b +: 8] : 8'h00;
    end
  end

  // hp1_r is one above the search's upper bound, so low_r < hp1_r means the range is live.
  assign mid_sum     = {1'b0, low_r} + {1'b0, hp1_r} - {{CNT_W{1'b0}}, 1'b1};
  assign mid         = mid_sum[CNT_W:1];
  assign cnt_m1      = count_r - {{(CNT_W-1){1'b0}}, 1'b1};
  assign pos_m1      = pos_r - {{(CNT_W-1){1'b0}}, 1'b1};
  assign pos_m2      = pos_r - {{(CNT_W-2){1'b0}}, 2'd2};
  assign idx_ext     = {{CNT_W{1'b0}}, index_r};
  assign cnt_ext     = {{IW{1'b0}}, count_r};
  assign cnt_out_ext = {{CW{1'b0}}, count_r};

  always_comb begin
    sts          = '0;
    sts.kind     = kind_r;
    sts.full     = (count_r == CNT_W'(CAPACITY));
    sts.pos_zero = (pos_r == '0);
    sts.held_gt  = (rdata_r.name > name_r);
    sts.name_gt  = (name_r > rdata_r.name);
    sts.held_eq  = (rdata_r.name == name_r);
    sts.live     = (low_r < hp1_r);
    sts.idx_bad  = (idx_ext >= cnt_ext);
    sts.out_busy = out_valid_r && !out_ready;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r[IDX_W-1:0];
    wr_data = rdata_r;
    rd_en   = 1'b0;
    rd_addr = mid[IDX_W-1:0];
    if (cmd.add_start) begin
      rd_en   = (count_r != '0);
      rd_addr = cnt_m1[IDX_W-1:0];
    end else if (cmd.shift_step) begin
      // Move one entry up and fetch the next one below it in the same cycle.
      wr_en   = 1'b1;
      rd_en   = (pos_m1 != '0);
      rd_addr = pos_m2[IDX_W-1:0];
    end else if (cmd.add_place) begin
      wr_en        = 1'b1;
      wr_data.name  = name_r;
      wr_data.score = score_r;
    end else if (cmd.srch_read) begin
      rd_en = 1'b1;
    end else if (cmd.srch_hit) begin
      wr_en         = 1'b1;
      wr_addr       = mid[IDX_W-1:0];
      wr_data.name  = name_r;
      wr_data.score = score_r;
    end else if (cmd.read_issue) begin
      rd_en   = 1'b1;
      rd_addr = idx_ext[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.add_place) begin
        count_r <= count_r + {{(CNT_W-1){1'b0}}, 1'b1};
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r  <= in_kind;
      name_r  <= shaped;
      score_r <= in_entry_score;
      index_r <= in_entry_index;
    end
    if (cmd.add_start) begin
      pos_r <= count_r;
    end else if (cmd.shift_step) begin
      pos_r <= pos_m1;
    end
    if (cmd.srch_start) begin
      low_r <= '0;
      hp1_r <= count_r;
    end else if (cmd.srch_up) begin
      low_r <= mid + {{(CNT_W-1){1'b0}}, 1'b1};
    end else if (cmd.srch_down) begin
      hp1_r <= mid;
    end
    if (cmd.set_res) begin
      res_r <= cmd.res;
    end
    if (cmd.emit) begin
      out_count_r  <= cnt_out_ext[CW-1:0];
      out_status_r <= snst_pkg::ST_OK;
      out_name_r   <= '0;
      out_score_r  <= '0;
      case (res_r)
        snst_pkg::RES_ITEM: begin
          out_name_r  <= name_r;
          out_score_r <= score_r;
        end
        snst_pkg::RES_MEM: begin
          out_name_r  <= rdata_r.name;
          out_score_r <= rdata_r.score;
        end
        snst_pkg::RES_FULL:    out_status_r <= snst_pkg::ST_FULL;
        snst_pkg::RES_MISSING: out_status_r <= snst_pkg::ST_MISSING;
        snst_pkg::RES_RANGE:   out_status_r <= snst_pkg::ST_RANGE;
        default: begin
          out_status_r <= snst_pkg::ST_OK;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_name   = out_name_r;
  assign out_score  = out_score_r;
  assign out_count  = out_count_r;

endmodule
`default_nettype wire

>>> verif/sorted_name_score_table_core_test.sv
`timescale 1ns / 100ps
`default_nettype none
module sorted_name_score_table_core_test;
  import snst_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int NAME_LEN    = 8;
  localparam int RANDOM_OPS  = 600;

  typedef struct {
    kind_t                       kind;
    logic [NAME_W-1:0]           name;
    logic signed [SCORE_W-1:0]   score;
    logic [IDX_IN_W-1:0]         index;
    bit                          drain_first;
  } table_op_t;

  typedef struct {
    status_t                     status;
    logic [NAME_W-1:0]           name;
    logic signed [SCORE_W-1:0]   score;
    logic [COUNT_OUT_W-1:0]      count;
  } table_reply_t;

  logic clk;
  logic rst_n;

  snst_in_if  in_ch();
  snst_out_if out_ch();

  sorted_name_score_table_core #(
    .CAPACITY(TABLE_DEPTH),
    .NAME_CHARS(NAME_LEN)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Predicted contents of the table.
  logic [NAME_W-1:0]         table_names [TABLE_DEPTH];
  logic signed [SCORE_W-1:0] table_scores [TABLE_DEPTH];
  int                        table_fill = 0;

  table_op_t    pending_ops[$];
  table_reply_t awaited_replies[$];
  // Shaped names the table will hold, in arrival order, as seen while building stimulus.
  logic [NAME_W-1:0] listed_names[$];

  table_op_t cur_op;
  int n_total;
  int n_accepted = 0;
  int n_received = 0;
  int n_faults = 0;
  int gap_left;
  int stall_left;
  int hold_left;

  // Keep the first NAME_LEN characters and drop everything after the terminating zero.
  function automatic logic [NAME_W-1:0] trim_name(logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] n;
    bit cut;
    n = raw;
    cut = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (cut || b >= NAME_LEN) begin
        n[63-8*b -: 8] = 8'h00;
      end else if (n[63-8*b -: 8] == 8'h00) begin
        cut = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic table_reply_t apply_table_op(table_op_t op);
    table_reply_t r;
    logic [NAME_W-1:0] nm;
    int pos;
    int lo;
    int hi;
    int mid;
    nm = trim_name(op.name);
    r.status = ST_OK;
    r.name = '0;
    r.score = '0;
    case (op.kind)
      KIND_ADD: begin
        if (table_fill >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = table_fill;
          while (pos > 0 && table_names[pos-1] > nm) begin
            table_names[pos] = table_names[pos-1];
            table_scores[pos] = table_scores[pos-1];
            pos--;
          end
          table_names[pos] = nm;
          table_scores[pos] = op.score;
          table_fill++;
          r.name = nm;
          r.score = op.score;
        end
      end
      KIND_UPDATE: begin
        lo = 0;
        hi = table_fill - 1;
        r.status = ST_MISSING;
        while (lo <= hi && r.status == ST_MISSING) begin
          mid = (lo + hi) / 2;
          if (table_names[mid] == nm) begin
            table_scores[mid] = op.score;
            r.status = ST_OK;
            r.name = nm;
            r.score = op.score;
          end else if (nm > table_names[mid]) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
      end
      KIND_READ: begin
        if (int'(op.index) >= table_fill) begin
          r.status = ST_RANGE;
        end else begin
          r.name = table_names[op.index];
          r.score = table_scores[op.index];
        end
      end
      default: begin
      end
    endcase
    r.count = table_fill[COUNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic logic [NAME_W-1:0] pack_name(string s);
    logic [NAME_W-1:0] n;
    n = '0;
    for (int i = 0; i < s.len() && i < 8; i++) begin
      n[63-8*i -: 8] = s[i];
    end
    return n;
  endfunction

  // Half the time, fill the bytes after the terminating zero with rubbish.
  function automatic logic [NAME_W-1:0] add_junk(logic [NAME_W-1:0] n);
    logic [NAME_W-1:0] j;
    bit cut;
    j = n;
    cut = 1'b0;
    if ($urandom_range(0, 1) == 0) begin
      for (int b = 0; b < 8; b++) begin
        if (cut) begin
          j[63-8*b -: 8] = 8'($urandom_range(0, 255));
        end else if (j[63-8*b -: 8] == 8'h00) begin
          cut = 1'b1;
        end
      end
    end
    return j;
  endfunction

  function automatic logic [NAME_W-1:0] pick_name();
    logic [NAME_W-1:0] n;
    int r;
    int len;
    r = $urandom_range(0, 9);
    n = '0;
    if (r <= 2 && listed_names.size() > 0) begin
      n = add_junk(listed_names[$urandom_range(0, listed_names.size() - 1)]);
    end else if (r <= 5) begin
      // A small alphabet so that equal and near names turn up often.
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        n[63-8*i -: 8] = 8'h41 + 8'($urandom_range(0, 3));
      end
      n = add_junk(n);
    end else if (r <= 7) begin
      n = {$urandom, $urandom};
    end else if (r == 8) begin
      n = {$urandom, $urandom};
      len = $urandom_range(0, 7);
      n[63-8*len -: 8] = 8'h00;
    end else begin
      case ($urandom_range(0, 2))
        0: n = '0;
        1: n = '1;
        default: n = 64'h8000_0000_0000_0000;
      endcase
    end
    return n;
  endfunction

  function automatic logic signed [SCORE_W-1:0] pick_score();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_op(kind_t kind, logic [NAME_W-1:0] name,
                                   logic signed [SCORE_W-1:0] score,
                                   logic [IDX_IN_W-1:0] index, bit drain_first);
    table_op_t op;
    op.kind = kind;
    op.name = name;
    op.score = score;
    op.index = index;
    op.drain_first = drain_first;
    pending_ops.push_back(op);
    if (kind == KIND_ADD && listed_names.size() < TABLE_DEPTH) begin
      listed_names.push_back(trim_name(name));
    end
  endfunction

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    fork
      forever #2 clk = ~clk;
    join_none
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("sorted_name_score_table_core_test NOT OK");
    $finish;
  end

  initial begin
    int r;

    // Empty table: nothing to read or update.
    queue_op(KIND_READ, '0, '0, 6'd0, 1'b0);
    queue_op(KIND_UPDATE, pack_name("ALICE"), 32'sd9, '0, 1'b0);
    queue_op(KIND_NONE, '1, '1, '1, 1'b0);
    // Inserts at the ends, an empty name and names equal after shaping.
    queue_op(KIND_ADD, pack_name("MIKE"), 32'sh7FFF_FFFF, '0, 1'b0);
    queue_op(KIND_ADD, '1, 32'sh8000_0000, '1, 1'b0);
    queue_op(KIND_ADD, '0, -32'sd1, '0, 1'b0);
    queue_op(KIND_ADD, pack_name("MIKE"), 32'sd5, '0, 1'b0);
    queue_op(KIND_ADD, 64'h4D49_0012_3456_789A, 32'sd6, '0, 1'b0);
    queue_op(KIND_ADD, pack_name("MIKE"), 32'sd7, '0, 1'b0);
    queue_op(KIND_UPDATE, pack_name("MIKE"), 32'sd100, '0, 1'b0);
    queue_op(KIND_UPDATE, 64'h4D49_00FF_FFFF_FFFF, 32'sd200, '0, 1'b0);
    queue_op(KIND_UPDATE, '0, 32'sd300, '0, 1'b0);
    queue_op(KIND_UPDATE, pack_name("ZED"), 32'sd400, '0, 1'b0);
    queue_op(KIND_ADD, 64'h00AB_CDEF_0102_0304, 32'sd8, '0, 1'b0);
    for (int i = 0; i < 8; i++) begin
      queue_op(KIND_READ, '0, '0, i[IDX_IN_W-1:0], 1'b0);
    end
    queue_op(KIND_READ, '1, '1, 6'd63, 1'b0);
    queue_op(KIND_NONE, '0, '0, '0, 1'b0);

    for (int i = 0; i < RANDOM_OPS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        queue_op(KIND_ADD, pick_name(), pick_score(), IDX_IN_W'($urandom), i == 300);
      end else if (r < 55) begin
        if (listed_names.size() > 0 && $urandom_range(0, 9) < 7) begin
          queue_op(KIND_UPDATE,
                   add_junk(listed_names[$urandom_range(0, listed_names.size() - 1)]),
                   pick_score(), IDX_IN_W'($urandom), i == 300);
        end else begin
          queue_op(KIND_UPDATE, pick_name(), pick_score(), IDX_IN_W'($urandom), i == 300);
        end
      end else if (r < 95) begin
        if (listed_names.size() > 0 && $urandom_range(0, 9) < 8) begin
          queue_op(KIND_READ, pick_name(), $urandom,
                   IDX_IN_W'($urandom_range(0, listed_names.size() - 1)), i == 300);
        end else begin
          queue_op(KIND_READ, pick_name(), $urandom, IDX_IN_W'($urandom_range(0, 63)),
                   i == 300);
        end
      end else begin
        queue_op(KIND_NONE, pick_name(), $urandom, IDX_IN_W'($urandom), i == 300);
      end
    end
    n_total = pending_ops.size();

    while (n_accepted < n_total || awaited_replies.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (n_faults == 0 && awaited_replies.size() == 0) begin
      $display("sorted_name_score_table_core_test OK");
    end else begin
      $display("sorted_name_score_table_core_test NOT OK");
    end
    $finish;
  end

  // Sender. The prediction is made as each beat is taken.
  always @(posedge clk) begin
    bit offering;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      offering = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        awaited_replies.push_back(apply_table_op(cur_op));
        n_accepted++;
        offering = 1'b0;
        gap_left = ((n_accepted / 40) % 3 == 1) ? 0 : $urandom_range(0, 8);
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].drain_first && awaited_replies.size() != 0)) begin
          cur_op = pending_ops.pop_front();
          in_ch.kind <= cur_op.kind;
          in_ch.entry_name <= cur_op.name;
          in_ch.entry_score <= cur_op.score;
          in_ch.entry_index <= cur_op.index;
          offering = 1'b1;
        end
      end
      in_ch.valid <= offering;
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_received++;
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected result beat, status %0d name %h score %0d count %0d",
                   $time, out_ch.status, out_ch.out_name, out_ch.out_score,
                   out_ch.out_count);
          n_faults++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_ch.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status,
                     out_ch.status);
            n_faults++;
          end
          if (out_ch.out_name !== want.name) begin
            $display("%0t: name expected %h, got %h", $time, want.name, out_ch.out_name);
            n_faults++;
          end
          if (out_ch.out_score !== want.score) begin
            $display("%0t: score expected %0d, got %0d", $time, want.score,
                     out_ch.out_score);
            n_faults++;
          end
          if (out_ch.out_count !== want.count) begin
            $display("%0t: count expected %0d, got %0d", $time, want.count,
                     out_ch.out_count);
            n_faults++;
          end
        end
        stall_left = ((n_received / 40) % 3 == 2) ? 0 : $urandom_range(0, 8);
        // One long hold-off, so that the block backs up and refuses input.
        if (n_received == 200) begin
          hold_left = 400;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
